/* sv/tda_pkg.sv */
// Package: shared types and constants for the track distance accumulator.
package tda_pkg;
  localparam int AccBits = 48;

  typedef enum logic [1:0] {
    KIND_FIX   = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_SPARE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_ORIG,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SQ,
    PH_RT
  } hyp_phase_t;
endpackage

/* sv/tda_if.sv */
// Interfaces: input and output channels of the accumulator.
interface tda_in_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  modport source (output valid, kind, pos_x, pos_y, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, output ready);
endinterface

interface tda_out_if #(parameter int COORD_BITS = 24, parameter int COUNT_BITS = 20);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] final_x;
  logic signed [COORD_BITS-1:0] final_y;
  logic [47:0]                  path_length;
  logic [COORD_BITS:0]          origin_distance;
  logic [COORD_BITS:0]          mean_origin_distance;
  logic [COUNT_BITS-1:0]        fix_count;
  modport source (output valid, final_x, final_y, path_length, origin_distance,
                  mean_origin_distance, fix_count, input ready);
  modport sink   (input valid, final_x, final_y, path_length, origin_distance,
                  mean_origin_distance, fix_count, output ready);
endinterface

/* sv/track_distance_accumulator_core.sv */
// Top level: path length and origin distance accumulator over position fixes.
// Sequence: a counted fix runs two serial roots in the hypot unit, the step root
// and then the origin root; a stop fix adds a serial division and the output beat.
// Fixes accepted while not tracking, start fixes among them, stay in the idle state.
// Flow: one fix at a time, none accepted until the block is idle; input held off while a result beat waits.
// Reset (rst, synchronous): not tracking, accumulators and count cleared.
module track_distance_accumulator_core #(
  parameter int COORD_BITS = 24,
  parameter int COUNT_BITS = 20
) (
  input logic clk,
  input logic rst,
  tda_in_if.sink    in_ch,
  tda_out_if.source out_ch
);
  localparam int DW = COORD_BITS + 1;
  localparam int AW = tda_pkg::AccBits;
  localparam int DCW = $clog2(AW + 1);

  tda_pkg::state_t state, state_next;

  logic                         tracking;
  logic signed [COORD_BITS-1:0] origin_x, origin_y, last_x, last_y, cur_x, cur_y;
  logic                         is_stop;
  logic [AW-1:0]                path_total, origin_sum;
  logic [COUNT_BITS-1:0]        counted;
  logic [DW-1:0]                odist;

  logic             h_start, h_done;
  logic [DW-1:0]    mag_a, mag_b;
  logic [DW:0]      h_root;
  logic signed [COORD_BITS:0] da, db;

  logic [AW-1:0]    dq;
  logic [COUNT_BITS:0] drem;
  logic [DCW-1:0]   dcnt;
  logic [COUNT_BITS:0] drem_sh;

  logic [AW:0]      acc_sum;
  logic             accept;

  assign in_ch.ready = (state == tda_pkg::ST_IDLE) && !out_ch.valid;
  assign accept = in_ch.valid && in_ch.ready;

  // the origin root is launched as the step root completes
  always_comb begin
    if (state == tda_pkg::ST_STEP) begin
      da = (COORD_BITS+1)'(cur_x) - (COORD_BITS+1)'(origin_x);
      db = (COORD_BITS+1)'(cur_y) - (COORD_BITS+1)'(origin_y);
    end else begin
      da = (COORD_BITS+1)'(in_ch.pos_x) - (COORD_BITS+1)'(last_x);
      db = (COORD_BITS+1)'(in_ch.pos_y) - (COORD_BITS+1)'(last_y);
    end
    mag_a = da[COORD_BITS] ? DW'(-da) : DW'(da);
    mag_b = db[COORD_BITS] ? DW'(-db) : DW'(db);
  end

  always_comb begin
    h_start = 1'b0;
    if (accept && tracking) h_start = 1'b1;
    if (state == tda_pkg::ST_STEP && h_done) h_start = 1'b1;
  end

  tda_hypot #(.W(DW)) u_hyp (
    .clk(clk), .rst(rst), .start(h_start), .mag_a(mag_a), .mag_b(mag_b),
    .done(h_done), .root(h_root)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      tda_pkg::ST_IDLE: if (accept && tracking) state_next = tda_pkg::ST_STEP;
      tda_pkg::ST_STEP: if (h_done) state_next = tda_pkg::ST_ORIG;
      tda_pkg::ST_ORIG: if (h_done) state_next = is_stop ? tda_pkg::ST_DIV
                                                          : tda_pkg::ST_IDLE;
      tda_pkg::ST_DIV:  if (dcnt == DCW'(0)) state_next = tda_pkg::ST_OUT;
      tda_pkg::ST_OUT:  state_next = tda_pkg::ST_IDLE;
      default:          state_next = tda_pkg::ST_IDLE;
    endcase
  end

  assign acc_sum = (state == tda_pkg::ST_STEP) ? {1'b0, path_total} + (AW+1)'(h_root)
                                               : {1'b0, origin_sum} + (AW+1)'(h_root);
  assign drem_sh = {drem[COUNT_BITS-1:0], dq[AW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tda_pkg::ST_IDLE;
      tracking   <= 1'b0;
      origin_x   <= '0;
      origin_y   <= '0;
      last_x     <= '0;
      last_y     <= '0;
      path_total <= '0;
      origin_sum <= '0;
      counted    <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        tda_pkg::ST_IDLE: if (accept) begin
          cur_x   <= in_ch.pos_x;
          cur_y   <= in_ch.pos_y;
          is_stop <= (in_ch.kind == tda_pkg::KIND_STOP);
          if (!tracking) begin
            if (in_ch.kind == tda_pkg::KIND_START) begin
              tracking   <= 1'b1;
              origin_x   <= in_ch.pos_x;
              origin_y   <= in_ch.pos_y;
              last_x     <= in_ch.pos_x;
              last_y     <= in_ch.pos_y;
              path_total <= '0;
              origin_sum <= '0;
              counted    <= '0;
            end
          end else begin
            last_x <= in_ch.pos_x;
            last_y <= in_ch.pos_y;
            if (counted != {COUNT_BITS{1'b1}}) counted <= counted + 1'b1;
          end
        end
        tda_pkg::ST_STEP: if (h_done) begin
          path_total <= acc_sum[AW] ? {AW{1'b1}} : acc_sum[AW-1:0];
        end
        tda_pkg::ST_ORIG: if (h_done) begin
          origin_sum <= acc_sum[AW] ? {AW{1'b1}} : acc_sum[AW-1:0];
          odist      <= h_root[DW-1:0];
          dq         <= acc_sum[AW] ? {AW{1'b1}} : acc_sum[AW-1:0];
          drem       <= '0;
          dcnt       <= DCW'(AW);
        end
        tda_pkg::ST_DIV: if (dcnt != DCW'(0)) begin
          dcnt <= dcnt - 1'b1;
          if (drem_sh >= {1'b0, counted}) begin
            drem <= drem_sh - {1'b0, counted};
            dq   <= {dq[AW-2:0], 1'b1};
          end else begin
            drem <= drem_sh;
            dq   <= {dq[AW-2:0], 1'b0};
          end
        end
        tda_pkg::ST_OUT: begin
          out_ch.valid                <= 1'b1;
          out_ch.final_x              <= cur_x;
          out_ch.final_y              <= cur_y;
          out_ch.path_length          <= path_total;
          out_ch.origin_distance      <= odist;
          out_ch.mean_origin_distance <= (dq > AW'({DW{1'b1}})) ? {DW{1'b1}}
                                                                : dq[DW-1:0];
          out_ch.fix_count            <= counted;
          tracking                    <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != tda_pkg::ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_out_after_div: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state) == tda_pkg::ST_OUT) else $error("stray result");
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == tda_pkg::ST_DIV) |-> counted != '0) else $error("zero count");
endmodule

/* sv/tda_hypot.sv */
// Bit-serial floor(sqrt(dx*dx+dy*dy)): squares by shift-add, root by restoring digits.
module tda_hypot #(
  parameter int W = 25
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] mag_a,
  input  logic [W-1:0] mag_b,
  output logic         done,
  output logic [W:0]   root
);
  localparam int SW = 2 * W + 2;
  localparam int CW = $clog2(W + 2) + 1;

  tda_pkg::hyp_phase_t phase, phase_next;
  logic [CW-1:0]    cnt;
  logic [W-1:0]     ma, mb;
  logic [W-1:0]     mpa, mpb;
  logic [SW-1:0]    sum;
  logic [SW+1:0]    rem;
  logic [W:0]       q;
  logic [SW+1:0]    rem_sh;
  logic [SW+1:0]    trial;

  always_comb begin
    rem_sh = {rem[SW-1:0], sum[SW-1 -: 2]};
    trial  = {{(SW-W-1){1'b0}}, q, 2'b01};
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      tda_pkg::PH_IDLE: if (start) phase_next = tda_pkg::PH_SQ;
      tda_pkg::PH_SQ:   if (cnt == CW'(1)) phase_next = tda_pkg::PH_RT;
      tda_pkg::PH_RT:   if (cnt == CW'(1)) phase_next = tda_pkg::PH_IDLE;
      default:          phase_next = tda_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      phase <= tda_pkg::PH_IDLE;
    end else begin
      phase <= phase_next;
      unique case (phase)
        tda_pkg::PH_IDLE: if (start) begin
          ma    <= mag_a;
          mb    <= mag_b;
          mpa   <= mag_a;
          mpb   <= mag_b;
          sum   <= '0;
          cnt   <= CW'(W);
        end
        tda_pkg::PH_SQ: begin
          sum <= sum + (mpa[W-1] ? SW'(ma) << (cnt - 1'b1) : '0)
                     + (mpb[W-1] ? SW'(mb) << (cnt - 1'b1) : '0);
          mpa <= mpa << 1;
          mpb <= mpb << 1;
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            rem   <= '0;
            q     <= '0;
            cnt   <= CW'(W + 1);
          end
        end
        tda_pkg::PH_RT: begin
          sum <= sum << 2;
          if (rem_sh >= trial) begin
            rem <= rem_sh - trial;
            q   <= {q[W-1:0], 1'b1};
          end else begin
            rem <= rem_sh;
            q   <= {q[W-1:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            done  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign root = q;
endmodule
